// ----- sv/bmb_pkg.sv -----
package bmb_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;

    // Field widths of the channels
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREQ     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic start;    // item accepted: capture it and arm the scan
        logic scan;     // walk the store, newest entry first
        logic fin;      // commit the operation and load the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_need;  // accepted item needs a scan of a non-empty store
        logic scan_done;  // scan reached a match that ends it, or the oldest entry
        logic out_free;   // result register can take a new result this cycle
    } t_sts;

endpackage

// ----- sv/bmb_in_if.sv -----
interface bmb_in_if import bmb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// ----- sv/bmb_out_if.sv -----
interface bmb_out_if import bmb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [CNT_W-1:0] frequency;
    logic [CNT_W-1:0] count;
    logic             empty_res;

    modport source (output valid, output ok, output frequency, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input ok, input frequency, input count,
                    input empty_res, output ready);
endinterface

// ----- sv/bmb_ram.sv -----
module bmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bmb_ctrl.sv -----
module bmb_ctrl import bmb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.scan_need ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/bmb_dp.sv -----
module bmb_dp import bmb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_ok,
    output logic [CNT_W-1:0]   o_frequency,
    output logic [CNT_W-1:0]   o_count,
    output logic               o_empty_res
);

    // captured item
    logic [MODE_W-1:0]     r_mode;
    logic [ITEM_WIDTH-1:0] r_value;
    logic [CNT_W-1:0]      r_held;

    // scan: read issue side
    logic [ADDR_W-1:0] r_addr;
    logic              r_more;
    logic              r_first_pend;
    // scan: compare side, registered behind the read
    logic              r_rd_vld;
    logic              r_rd_first;
    logic [ADDR_W-1:0] r_rd_idx;

    logic [ITEM_WIDTH-1:0] r_last;
    logic                  r_found;
    logic [ADDR_W-1:0]     r_match_idx;
    logic [CNT_W-1:0]      r_freq;

    // result register
    logic             r_out_vld;
    logic             r_ok;
    logic [CNT_W-1:0] r_frq;
    logic [CNT_W-1:0] r_cnt;
    logic             r_empty;

    logic [ITEM_WIDTH-1:0] rdata;
    logic                  match;
    logic                  issue;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic [CNT_W-1:0]      n_held;
    logic                  n_ok;

    bmb_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign issue = i_cmd.scan && r_more;
    assign match = r_rd_vld && (rdata == r_value);

    always_comb begin
        o_sts.scan_need = (i_mode inside {MODE_REMOVE, MODE_CONTAINS, MODE_FREQ})
                          && (r_held != '0);
        o_sts.scan_done = r_rd_vld && ((match && (r_mode != MODE_FREQ))
                                       || (r_rd_idx == '0));
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    // commit of the operation
    always_comb begin
        we     = 1'b0;
        waddr  = r_match_idx;
        wdata  = r_last;
        n_held = r_held;
        n_ok   = 1'b0;
        case (r_mode)
            MODE_ADD: begin
                waddr = r_held[ADDR_W-1:0];
                wdata = r_value;
                if (r_held < CNT_W'(CAPACITY)) begin
                    we     = i_cmd.fin;
                    n_held = r_held + 1'b1;
                    n_ok   = 1'b1;
                end
            end
            MODE_REMOVE: begin
                // move the newest entry into the hole
                if (r_found) begin
                    we     = i_cmd.fin;
                    n_held = r_held - 1'b1;
                    n_ok   = 1'b1;
                end
            end
            MODE_CONTAINS: begin
                n_ok = r_found;
            end
            MODE_CLEAR: begin
                n_held = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_value <= i_value[ITEM_WIDTH-1:0];
            r_found <= 1'b0;
            r_freq  <= '0;
        end
        if (i_cmd.start) begin
            r_addr       <= ADDR_W'(r_held - 1'b1);
            r_first_pend <= 1'b1;
        end else if (issue) begin
            r_addr       <= r_addr - 1'b1;
            r_first_pend <= 1'b0;
        end
        r_rd_first <= r_first_pend;
        r_rd_idx   <= r_addr;

        if (i_cmd.scan) begin
            if (r_rd_vld && r_rd_first) begin
                r_last <= rdata;
            end
            if (match) begin
                r_freq <= r_freq + 1'b1;
                if (!r_found) begin
                    r_found     <= 1'b1;
                    r_match_idx <= r_rd_idx;
                end
            end
        end

        if (i_cmd.fin) begin
            r_ok    <= n_ok;
            r_frq   <= (r_mode == MODE_FREQ) ? r_freq : '0;
            r_cnt   <= n_held;
            r_empty <= (n_held == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_more    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_held <= n_held;
            end
            if (i_cmd.start) begin
                r_more <= 1'b1;
            end else if (issue && (r_addr == '0)) begin
                r_more <= 1'b0;
            end
            r_rd_vld <= issue;
            if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_ok        = r_ok;
    assign o_frequency = r_frq;
    assign o_count     = r_cnt;
    assign o_empty_res = r_empty;

endmodule

// ----- sv/bounded_multiset_bag_core.sv -----
// Bounded multiset of 32-bit values, up to CAPACITY entries.
// Input channel i_in (valid/ready) takes one item: an operation code
// (add, remove, contains, frequency, clear) and a value. Output channel
// o_res (valid/ready) returns exactly one result per item: ok flag,
// frequency, entry count after the operation and an empty flag.
// Add, clear, unused codes and any lookup on an empty bag go from accept
// straight to the commit step, which loads the result register.
// Remove, contains and frequency walk the entry RAM one entry a cycle,
// newest first, through its single registered read port, then commit;
// remove and contains stop at the first match, frequency walks down to
// the oldest entry.
// One item is in work at a time; the next is taken once the previous one
// has committed, even while its result still waits.
// Reset empties the bag (count zero) and drops any pending result; the
// RAM contents are left as they are and are never read before written.
// A stalled receiver holds the result in its register; a following item
// is then held at its final commit step until the register frees up.
module bounded_multiset_bag_core import bmb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bmb_in_if.sink    i_in,
    bmb_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle, scan, commit
    bmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready)
    );

    // entry RAM, count, scan pipeline and result register
    bmb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_in.mode),
        .i_value     (i_in.value),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_ok        (o_res.ok),
        .o_frequency (o_res.frequency),
        .o_count     (o_res.count),
        .o_empty_res (o_res.empty_res)
    );

endmodule

// ----- verif/multiset_bag_checker.sv -----
`timescale 1ns / 100ps

module multiset_bag_checker import bmb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bmb_in_if    i_in_mon,
    bmb_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] frequency;
        logic [CNT_W-1:0] count;
        logic             empty_res;
    } t_bag_result;

    // Shadow copy of the bag: slots below held_n are live, newest on top
    logic [ITEM_WIDTH-1:0] slots [CAPACITY];
    int                    held_n = 0;
    t_bag_result           awaited_results [$];
    int                    mismatches = 0;
    int                    pending_n = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    // Apply one operation to the shadow bag and return the result it gives
    function automatic t_bag_result bag_apply(input logic [MODE_W-1:0]  op,
                                              input logic [VALUE_W-1:0] raw);
        logic [ITEM_WIDTH-1:0] v;
        int                    hit;
        int                    hit_count;
        t_bag_result           r;
        v         = ITEM_WIDTH'(raw);
        hit       = -1;
        hit_count = 0;
        r         = '0;
        for (int i = held_n - 1; i >= 0; i--) begin
            if (slots[i] == v) begin
                hit_count++;
                if (hit < 0) hit = i;
            end
        end
        case (op)
            MODE_ADD: begin
                if (held_n < CAPACITY) begin
                    slots[held_n] = v;
                    held_n++;
                    r.ok = 1'b1;
                end
            end
            MODE_REMOVE: begin
                // fill the hole with the newest entry, then drop the top
                if (hit >= 0) begin
                    slots[hit] = slots[held_n - 1];
                    held_n--;
                    r.ok = 1'b1;
                end
            end
            MODE_CONTAINS: r.ok = (hit >= 0);
            MODE_FREQ:     r.frequency = CNT_W'(hit_count);
            MODE_CLEAR:    held_n = 0;
            default: ;
        endcase
        r.count     = CNT_W'(held_n);
        r.empty_res = (held_n == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_bag_result want;
        if (!i_rst_n) begin
            held_n = 0;
            awaited_results.delete();
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result ok=%0d freq=%0d count=%0d",
                                              i_res_mon.ok, i_res_mon.frequency,
                                              i_res_mon.count));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res_mon.ok !== want.ok)
                        report_mismatch($sformatf("ok: expected %0d got %0d",
                                                  want.ok, i_res_mon.ok));
                    if (i_res_mon.frequency !== want.frequency)
                        report_mismatch($sformatf("frequency: expected %0d got %0d",
                                                  want.frequency, i_res_mon.frequency));
                    if (i_res_mon.count !== want.count)
                        report_mismatch($sformatf("count: expected %0d got %0d",
                                                  want.count, i_res_mon.count));
                    if (i_res_mon.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res: expected %0d got %0d",
                                                  want.empty_res, i_res_mon.empty_res));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                awaited_results = {awaited_results,
                                   bag_apply(i_in_mon.mode, i_in_mon.value)};
        end
        pending_n = awaited_results.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bmb_pkg::*;

    // Codes past clear do nothing but report the count
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_CLEAR + 3'd1;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

    localparam int RANDOM_ITEMS    = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    // Settle time scales with CAPACITY and leaves room for stragglers
    localparam int SETTLE_CYCLES   = 2 * CAPACITY + 16;
    localparam int POOL_MAX        = 8;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} t_phase_kind;

    logic i_clk;
    logic i_rst_n;

    bmb_in_if  in_ch();
    bmb_out_if res_ch();

    int fail_count;
    int pending;

    // Stimulus knobs shared between processes
    bit                 no_gaps       = 1'b0;
    bit                 hold_off_req  = 1'b0;
    bit                 hold_off_done = 1'b0;
    logic [VALUE_W-1:0] pool [POOL_MAX];
    int                 pool_n        = 1;

    bounded_multiset_bag_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    multiset_bag_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values come mostly from a small pool so that adds, removes and
    // lookups hit each other; the rest are fully random words
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        // a little noise: any code, the unused ones included
        if (r < 5) return MODE_W'($urandom_range(0, 2 ** MODE_W - 1));
        case (kind)
            PH_FILL: begin
                if (r < 85) return MODE_ADD;
                case ($urandom_range(0, 2))
                    0:       return MODE_REMOVE;
                    1:       return MODE_CONTAINS;
                    default: return MODE_FREQ;
                endcase
            end
            PH_DRAIN: begin
                if (r < 15) return MODE_ADD;
                if (r < 65) return MODE_REMOVE;
                if (r < 80) return MODE_CONTAINS;
                return MODE_FREQ;
            end
            default: begin
                if (r < 35) return MODE_ADD;
                if (r < 55) return MODE_REMOVE;
                if (r < 70) return MODE_CONTAINS;
                if (r < 95) return MODE_FREQ;
                return MODE_CLEAR;
            end
        endcase
    endfunction

    // Offer one item after an optional idle gap; return at the edge that takes it
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op;
        in_ch.value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Result side: random stalls, long ready stretches, and one long hold-off
    initial begin
        int run_len;
        int stall;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                // hold off while the sender streams, so the block backs up
                hold_off_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            run_len = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 150)
                                                 : $urandom_range(1, 6);
            repeat (run_len) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Input side: reset, directed items, random phases, then the verdict
    initial begin
        int          sent;
        int          len;
        t_phase_kind kind;
        in_ch.valid <= 1'b0;
        in_ch.mode  <= MODE_ADD;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty bag: remove misses, lookups find nothing
        send_item(MODE_REMOVE,   32'h0000_0005);
        send_item(MODE_CONTAINS, 32'h0000_0000);
        send_item(MODE_FREQ,     32'h0000_0000);
        // Extremes and a duplicate
        send_item(MODE_ADD,      32'h0000_0000);
        send_item(MODE_ADD,      32'hFFFF_FFFF);
        send_item(MODE_ADD,      32'h0000_0000);
        send_item(MODE_ADD,      32'h5A5A_5A5A);
        send_item(MODE_CONTAINS, 32'hFFFF_FFFF);
        send_item(MODE_CONTAINS, 32'h1234_5678);
        send_item(MODE_FREQ,     32'h0000_0000);
        // Remove the newer zero: the top entry moves into its slot
        send_item(MODE_REMOVE,   32'h0000_0000);
        send_item(MODE_FREQ,     32'h0000_0000);
        send_item(MODE_CONTAINS, 32'h5A5A_5A5A);
        // Remove with no match leaves the bag alone
        send_item(MODE_REMOVE,   32'hDEAD_BEEF);
        // Unused codes only report the count
        send_item(MODE_SPARE_FIRST, 32'hFFFF_FFFF);
        send_item(MODE_SPARE_FIRST + 3'd1, 32'h0000_0000);
        send_item(MODE_SPARE_LAST, 32'h5A5A_5A5A);
        // Clear keeps stale contents out of reach
        send_item(MODE_CLEAR,    32'h0000_0000);
        send_item(MODE_CONTAINS, 32'h0000_0000);
        send_item(MODE_CLEAR,    32'hFFFF_FFFF);
        // Remove the newest entry itself, then the last one
        send_item(MODE_ADD,      32'hAAAA_AAAA);
        send_item(MODE_ADD,      32'h5555_5555);
        send_item(MODE_REMOVE,   32'h5555_5555);
        send_item(MODE_REMOVE,   32'hAAAA_AAAA);

        // First random phase streams adds back to back into the hold-off,
        // so the bag and the result register both back up
        sent         = 0;
        kind         = PH_FILL;
        no_gaps      = 1'b1;
        hold_off_req = 1'b1;
        len          = 150;
        while (sent < RANDOM_ITEMS) begin
            pool_n = $urandom_range(1, POOL_MAX);
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 9))
                    0:       pool[i] = '0;
                    1:       pool[i] = '1;
                    default: pool[i] = $urandom;
                endcase
            end
            // start from empty half the time, so a one-value pool can reach
            // a frequency of CAPACITY and fills run into the full bag
            if ($urandom_range(0, 1) == 0) begin
                send_item(MODE_CLEAR, pick_value());
                sent++;
            end
            for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
                send_item(pick_mode(kind), pick_value());
                sent++;
            end
            kind    = t_phase_kind'($urandom_range(0, 2));
            no_gaps = ($urandom_range(0, 3) == 0);
            len     = (kind == PH_FILL) ? $urandom_range(70, 130) : $urandom_range(30, 100);
        end
        in_ch.valid <= 1'b0;

        // Drain, then let the settle time pass for strays
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
